// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the dispatcher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ante implies cons on the same clock edge
`define DP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dispatcher check failed");
// cond never holds
`define DP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("dispatcher check failed");
`endif

// ----- rtl/core/dp_pkg.sv -----
// Shared types, codes and helpers of the job dispatcher.
// No dependencies; used by every dispatcher module.
package dp_pkg;

    localparam int NUM_CORES_DEF   = 8;
    localparam int NUM_TYPES_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int JOB_ID_BITS_DEF = 16;

    localparam int ID_W = 16;   // job id field width on the ports
    localparam int MAP_W = 16;  // core type map width

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DONE = 2'd1,
        OP_DISP = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_TYPE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // classified request, front to back
    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [1:0]       ty;
        logic [2:0]       ci;
        logic             ci_ok;    // core index below core count
        logic             pin_ok;   // goes to the core's own FIFO
        logic             no_type;  // type out of range or no core of that type
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic             disp;
        logic [2:0]       core;
        logic [ID_W-1:0]  job;
        logic             pinq;
        logic [7:0]       pend;
        logic [3:0]       idle;
        logic             af;
        logic             last;
    } t_res;

    // cores eight and up have type zero
    function automatic logic [1:0] core_type(input logic [MAP_W-1:0] map,
                                             input logic [3:0] c);
        if (c[3]) return 2'd0;
        return map[{c[2:0], 1'b0} +: 2];
    endfunction

endpackage

// ----- rtl/core/dp_front.sv -----
// Front end: takes input requests and classifies them for the back end.
// Depends on dp_pkg.
module dp_front #(
    parameter int NUM_CORES = dp_pkg::NUM_CORES_DEF,
    parameter int NUM_TYPES = dp_pkg::NUM_TYPES_DEF
) (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [dp_pkg::ID_W-1:0]   i_job_id,
    input  logic [1:0]                i_job_type,
    input  logic                      i_pinned,
    input  logic [2:0]                i_core_index,
    input  logic [dp_pkg::MAP_W-1:0]  i_map,
    output logic                      o_push,
    output dp_pkg::t_cmd              o_cmd,
    input  logic                      i_q_ready
);
    logic present;
    logic ci_ok;

    always_comb begin
        present = 1'b0;
        for (int c = 0; c < NUM_CORES; c++) begin
            if (dp_pkg::core_type(i_map, 4'(c)) == i_job_type) present = 1'b1;
        end
    end

    assign ci_ok = int'(i_core_index) < NUM_CORES;

    always_comb begin
        o_cmd.op      = dp_pkg::t_op'(i_opcode);
        o_cmd.id      = i_job_id;
        o_cmd.ty      = i_job_type;
        o_cmd.ci      = i_core_index;
        o_cmd.ci_ok   = ci_ok;
        o_cmd.pin_ok  = i_pinned && ci_ok;
        o_cmd.no_type = !(int'(i_job_type) < NUM_TYPES) || !present;
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
endmodule

// ----- rtl/core/dp_cmdq.sv -----
// Two-entry request queue between the front and back ends.
// Depends on dp_pkg.
module dp_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dp_pkg::t_cmd  i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output dp_pkg::t_cmd  o_cmd,
    input  logic          i_pop
);
    dp_pkg::t_cmd r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ----- rtl/core/dp_back.sv -----
// Back end: job FIFOs, core busy flags, dispatch scan and result register.
// Depends on dp_pkg.
module dp_back #(
    parameter int NUM_CORES   = dp_pkg::NUM_CORES_DEF,
    parameter int NUM_TYPES   = dp_pkg::NUM_TYPES_DEF,
    parameter int QUEUE_DEPTH = dp_pkg::QUEUE_DEPTH_DEF,
    parameter int JOB_ID_BITS = dp_pkg::JOB_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [dp_pkg::MAP_W-1:0]  i_map,
    input  logic                      i_cmd_valid,
    input  dp_pkg::t_cmd              i_cmd,
    output logic                      o_cmd_pop,
    output dp_pkg::t_res              o_res,
    output logic                      o_res_valid,
    input  logic                      i_res_ready
);
    localparam int CIW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int TIW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int SW   = $clog2(QUEUE_DEPTH);
    localparam int NW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CAW  = $clog2(NUM_CORES * QUEUE_DEPTH);
    localparam int TAW  = $clog2(NUM_TYPES * QUEUE_DEPTH);
    localparam int PW   = $clog2((NUM_CORES + NUM_TYPES) * QUEUE_DEPTH + 1);
    localparam int IW   = $clog2(NUM_CORES + 1);
    localparam int CEW  = JOB_ID_BITS + 2;
    localparam int SUMW = NW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // job stores, no reset: only written slots are used
    logic [CEW-1:0]         r_cmem [NUM_CORES*QUEUE_DEPTH];
    logic [JOB_ID_BITS-1:0] r_tmem [NUM_TYPES*QUEUE_DEPTH];
    logic [CEW-1:0]         r_crd;
    logic [JOB_ID_BITS-1:0] r_trd;

    logic [SW-1:0]  r_cq_head [NUM_CORES];
    logic [NW-1:0]  r_cq_cnt  [NUM_CORES];
    logic [SW-1:0]  r_tq_head [NUM_TYPES];
    logic [NW-1:0]  r_tq_cnt  [NUM_TYPES];
    logic [NUM_CORES-1:0] r_busy;
    logic [PW-1:0]  r_pend;
    t_state         r_state;
    logic [CIW-1:0] r_c;

    // assignment held back until we know whether it is the last one
    logic                   r_hv, r_hpinq;
    logic [CIW-1:0]         r_hc;
    logic [JOB_ID_BITS-1:0] r_hj;
    logic [PW-1:0]          r_hpend;
    logic [IW-1:0]          r_hidle;

    dp_pkg::t_res r_out;
    logic         r_out_valid;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] h);
        return (h == SW'(QUEUE_DEPTH - 1)) ? '0 : h + SW'(1);
    endfunction

    function automatic logic [SW-1:0] tail(input logic [SW-1:0] h, input logic [NW-1:0] n);
        logic [SUMW-1:0] s;
        s = SUMW'(h) + SUMW'(n);
        if (s >= SUMW'(QUEUE_DEPTH)) s = s - SUMW'(QUEUE_DEPTH);
        return SW'(s);
    endfunction

    function automatic logic [CAW-1:0] cadr(input logic [CIW-1:0] c, input logic [SW-1:0] s);
        return CAW'(CAW'(c) * CAW'(QUEUE_DEPTH)) + CAW'(s);
    endfunction

    function automatic logic [TAW-1:0] tadr(input logic [TIW-1:0] t, input logic [SW-1:0] s);
        return TAW'(TAW'(t) * TAW'(QUEUE_DEPTH)) + TAW'(s);
    endfunction

    function automatic dp_pkg::t_res mk(input logic [1:0] st, input logic disp,
                                        input logic [CIW-1:0] c,
                                        input logic [JOB_ID_BITS-1:0] j,
                                        input logic pq, input logic [PW-1:0] p,
                                        input logic [IW-1:0] idl, input logic lst);
        dp_pkg::t_res r;
        r.status = st;
        r.disp   = disp;
        r.core   = 3'(c);
        r.job    = dp_pkg::ID_W'(j);
        r.pinq   = pq;
        r.pend   = 8'(p);
        r.idle   = 4'(idl);
        r.af     = (idl == IW'(NUM_CORES)) && (p == '0);
        r.last   = lst;
        return r;
    endfunction

    logic [IW-1:0] idle_now;
    always_comb begin
        idle_now = '0;
        for (int c = 0; c < NUM_CORES; c++) idle_now = idle_now + IW'(!r_busy[c]);
    end

    // ---- request side
    logic [CIW-1:0]         eci;
    logic [TIW-1:0]         ety;
    logic [JOB_ID_BITS-1:0] eid;
    logic                   e_cw, e_tw, out_free, exec_now;
    logic [1:0]             e_st;
    logic [SW-1:0]          e_cslot, e_tslot;

    assign eci = CIW'(i_cmd.ci);
    assign ety = TIW'(i_cmd.ty);
    assign eid = JOB_ID_BITS'(i_cmd.id);
    assign e_cslot = tail(r_cq_head[eci], r_cq_cnt[eci]);
    assign e_tslot = tail(r_tq_head[ety], r_tq_cnt[ety]);
    assign e_cw = i_cmd.pin_ok && (r_cq_cnt[eci] != NW'(QUEUE_DEPTH));
    assign e_tw = !i_cmd.pin_ok && !i_cmd.no_type && (r_tq_cnt[ety] != NW'(QUEUE_DEPTH));

    always_comb begin
        if (i_cmd.pin_ok)       e_st = e_cw ? dp_pkg::ST_OK : dp_pkg::ST_FULL;
        else if (i_cmd.no_type) e_st = dp_pkg::ST_NO_TYPE;
        else                    e_st = e_tw ? dp_pkg::ST_OK : dp_pkg::ST_FULL;
    end

    assign out_free  = !r_out_valid || i_res_ready;
    assign exec_now  = (r_state == S_IDLE) && i_cmd_valid &&
                       (i_cmd.op != dp_pkg::OP_DISP) && out_free;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid &&
                       ((i_cmd.op == dp_pkg::OP_DISP) || out_free);

    // ---- scan side
    logic [1:0]             ctype;
    logic                   ct_ok, busy_c, take_pin, take_typ, take, ev_go, fin_go, scan_end;
    logic [TIW-1:0]         tsel;
    logic [JOB_ID_BITS-1:0] sjob;

    assign ctype    = dp_pkg::core_type(i_map, 4'(r_c));
    assign ct_ok    = int'(ctype) < NUM_TYPES;
    assign tsel     = ct_ok ? TIW'(ctype) : '0;
    assign busy_c   = r_busy[r_c];
    assign take_pin = !busy_c && (r_cq_cnt[r_c] != '0) && (r_crd[CEW-1 -: 2] == ctype);
    assign take_typ = !busy_c && !take_pin && ct_ok && (r_tq_cnt[tsel] != '0);
    assign take     = take_pin || take_typ;
    assign sjob     = take_pin ? r_crd[JOB_ID_BITS-1:0] : r_trd;
    assign ev_go    = (r_state == S_EV) && (!(take && r_hv) || out_free);
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign scan_end = r_c == CIW'(NUM_CORES - 1);

    // ---- memories
    always_ff @(posedge i_clk) begin
        if (exec_now && (i_cmd.op == dp_pkg::OP_ENQ) && e_cw)
            r_cmem[cadr(eci, e_cslot)] <= {i_cmd.ty, eid};
        if (r_state == S_RD) r_crd <= r_cmem[cadr(r_c, r_cq_head[r_c])];
    end

    always_ff @(posedge i_clk) begin
        if (exec_now && (i_cmd.op == dp_pkg::OP_ENQ) && e_tw)
            r_tmem[tadr(ety, e_tslot)] <= eid;
        if (r_state == S_RD) r_trd <= r_tmem[tadr(tsel, r_tq_head[tsel])];
    end

    // ---- result selection
    dp_pkg::t_res n_res;
    logic         load;

    always_comb begin
        n_res = mk(dp_pkg::ST_NONE, 1'b0, '0, '0, 1'b0, r_pend, idle_now, 1'b1);
        load  = 1'b0;
        if (exec_now) begin
            load = 1'b1;
            case (i_cmd.op)
                dp_pkg::OP_ENQ:
                    n_res = mk(e_st, 1'b0, '0, '0, 1'b0, r_pend + PW'(e_cw || e_tw),
                               idle_now, 1'b1);
                dp_pkg::OP_DONE:
                    n_res = mk(dp_pkg::ST_OK, 1'b0, '0, '0, 1'b0, r_pend,
                               idle_now + IW'(i_cmd.ci_ok && r_busy[eci]), 1'b1);
                default:
                    n_res = mk(dp_pkg::ST_OK, 1'b0, '0, '0, 1'b0, r_pend, idle_now, 1'b1);
            endcase
        end else if (ev_go && take && r_hv) begin
            load  = 1'b1;
            n_res = mk(dp_pkg::ST_OK, 1'b1, r_hc, r_hj, r_hpinq, r_hpend, r_hidle, 1'b0);
        end else if (fin_go) begin
            load = 1'b1;
            if (r_hv)
                n_res = mk(dp_pkg::ST_OK, 1'b1, r_hc, r_hj, r_hpinq, r_hpend, r_hidle, 1'b1);
        end
    end

    // ---- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CORES; c++) begin
                r_cq_head[c] <= '0;
                r_cq_cnt[c]  <= '0;
            end
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_tq_head[t] <= '0;
                r_tq_cnt[t]  <= '0;
            end
            r_busy      <= '0;
            r_pend      <= '0;
            r_state     <= S_IDLE;
            r_c         <= '0;
            r_hv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) r_out_valid <= 1'b1;
            else if (i_res_ready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && (i_cmd.op == dp_pkg::OP_DISP)) begin
                        r_c     <= '0;
                        r_hv    <= 1'b0;
                        r_state <= S_RD;
                    end else if (exec_now) begin
                        if (i_cmd.op == dp_pkg::OP_ENQ) begin
                            if (e_cw) r_cq_cnt[eci] <= r_cq_cnt[eci] + NW'(1);
                            if (e_tw) r_tq_cnt[ety] <= r_tq_cnt[ety] + NW'(1);
                            if (e_cw || e_tw) r_pend <= r_pend + PW'(1);
                        end else if (i_cmd.op == dp_pkg::OP_DONE && i_cmd.ci_ok) begin
                            r_busy[eci] <= 1'b0;
                        end
                    end
                end
                S_RD: r_state <= S_EV;
                S_EV: begin
                    if (ev_go) begin
                        if (take) begin
                            if (take_pin) begin
                                r_cq_head[r_c] <= wrap_inc(r_cq_head[r_c]);
                                r_cq_cnt[r_c]  <= r_cq_cnt[r_c] - NW'(1);
                            end else begin
                                r_tq_head[tsel] <= wrap_inc(r_tq_head[tsel]);
                                r_tq_cnt[tsel]  <= r_tq_cnt[tsel] - NW'(1);
                            end
                            r_busy[r_c] <= 1'b1;
                            r_pend      <= r_pend - PW'(1);
                            r_hv        <= 1'b1;
                            r_hc        <= r_c;
                            r_hj        <= sjob;
                            r_hpinq     <= take_pin;
                            r_hpend     <= r_pend - PW'(1);
                            r_hidle     <= idle_now - IW'(1);
                        end
                        if (scan_end) begin
                            r_state <= S_FIN;
                        end else begin
                            r_c     <= r_c + CIW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: if (fin_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_res;
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;
endmodule

// ----- rtl/core/pinned_and_shared_job_dispatcher.sv -----
// Top level of the pinned and shared job dispatcher.
// Depends on dp_pkg, dp_front, dp_cmdq, dp_back and assert_macros.svh.
//
// Usage:
//  - s_axis carries one request: tuser is the opcode (enqueue, done,
//    dispatch, no-op); tdata holds job id, job type, pinned flag, core index.
//  - m_axis returns results; tlast marks the final result of a request.
//    Enqueue, done and no-op give one result; a dispatch pass gives one
//    result per assigned core, or one "nothing dispatched" result.
//  - cfg channel writes the core type map (two bits per core, core 0 low);
//    ready is always high. Write it only while the block is idle.
// Request flow:
//  - A two-entry request queue parts front and back, so s_axis keeps
//    taking requests while a result waits on m_axis.
//  - Enqueue, done and no-op: the request passes the request queue, then its result is registered.
//  - Dispatch: the scan visits the cores from core 0 up, each with a job store
//    read, then a decide step that may wait on m_axis; one store port per FIFO set.
// Reset (i_rst_n, synchronous, low): FIFOs empty, all cores idle, map zero.
// A stalled m_axis holds its result and the back end waits before it loads
// another result; the front keeps filling the request queue until it is full.
`include "assert_macros.svh"
module pinned_and_shared_job_dispatcher #(
    parameter int NUM_CORES   = dp_pkg::NUM_CORES_DEF,
    parameter int NUM_TYPES   = dp_pkg::NUM_TYPES_DEF,
    parameter int QUEUE_DEPTH = dp_pkg::QUEUE_DEPTH_DEF,
    parameter int JOB_ID_BITS = dp_pkg::JOB_ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // job_id[15:0], job_type[17:16], pinned[18],
                                          // core_index[21:19], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // dispatched[0], out_core[3:1], out_job[19:4],
                                          // from_pinned_queue[20], pending_jobs[28:21],
                                          // idle_cores[32:29], all_finished[33], zero pad
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data        // core_type_map
);
    logic [dp_pkg::MAP_W-1:0] r_map;
    dp_pkg::t_cmd front_cmd, q_cmd;
    dp_pkg::t_res res;
    logic         push, q_ready, q_valid, pop;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cfg_valid) begin
            r_map <= i_cfg_data;
        end
    end

    dp_front #(.NUM_CORES(NUM_CORES), .NUM_TYPES(NUM_TYPES)) u_front (
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_opcode     (i_s_axis_tuser),
        .i_job_id     (i_s_axis_tdata[15:0]),
        .i_job_type   (i_s_axis_tdata[17:16]),
        .i_pinned     (i_s_axis_tdata[18]),
        .i_core_index (i_s_axis_tdata[21:19]),
        .i_map        (r_map),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .i_q_ready    (q_ready)
    );

    dp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    dp_back #(
        .NUM_CORES   (NUM_CORES),
        .NUM_TYPES   (NUM_TYPES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_map       (r_map),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_res       (res),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'd0, res.af, res.idle, res.pend, res.pinq, res.job,
                             res.core, res.disp};
    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tlast = res.last;

    // an assignment always reports ok
    `DP_ASSERT_IMP(a_disp_ok, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tuser == dp_pkg::ST_OK)
    // "nothing dispatched" is the only result of its pass
    `DP_ASSERT_IMP(a_none_last, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == dp_pkg::ST_NONE), o_m_axis_tlast)
    // all finished means no pending jobs and no assignment in this result
    `DP_ASSERT_IMP(a_af_pend, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[33],
        (o_m_axis_tdata[28:21] == 8'd0) && !o_m_axis_tdata[0])
    // a non-dispatch result carries no job
    `DP_ASSERT_NEVER(a_idle_job, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tdata[0] && (o_m_axis_tdata[20:1] != 20'd0))
endmodule
